// ----- src/clr_pkg.sv -----
package clr_pkg;

  localparam int CLIP_BITS     = 11;
  localparam int COLOR_BITS    = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = CLIP_BITS;

  localparam logic [CLIP_BITS-1:0] CLIP_LEFT_RST   = 11'd0;
  localparam logic [CLIP_BITS-1:0] CLIP_TOP_RST    = 11'd0;
  localparam logic [CLIP_BITS-1:0] CLIP_RIGHT_RST  = 11'd319;
  localparam logic [CLIP_BITS-1:0] CLIP_BOTTOM_RST = 11'd199;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_RIGHT  = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CLIP_BITS-1:0] left;
    logic [CLIP_BITS-1:0] top;
    logic [CLIP_BITS-1:0] right;
    logic [CLIP_BITS-1:0] bottom;
  } clip_t;

endpackage

// ----- src/clr_in_if.sv -----
interface clr_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [7:0]                   draw_color;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, draw_color,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, draw_color,
    output ready
  );
endinterface

// ----- src/clr_out_if.sv -----
interface clr_out_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [7:0]                   pixel_color;
  logic                         write_enable;
  logic                         line_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, write_enable, line_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, write_enable, line_done,
    output ready
  );
endinterface

// ----- src/clr_cfg.sv -----
module clr_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [clr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [clr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output clr_pkg::clip_t                  clip
);
  import clr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip.left   <= CLIP_LEFT_RST;
      clip.top    <= CLIP_TOP_RST;
      clip.right  <= CLIP_RIGHT_RST;
      clip.bottom <= CLIP_BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CLIP_LEFT:   clip.left   <= cfg_data[CLIP_BITS-1:0];
        CFG_CLIP_TOP:    clip.top    <= cfg_data[CLIP_BITS-1:0];
        CFG_CLIP_RIGHT:  clip.right  <= cfg_data[CLIP_BITS-1:0];
        CFG_CLIP_BOTTOM: clip.bottom <= cfg_data[CLIP_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/clr_engine.sv -----
module clr_engine #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  clr_pkg::clip_t                      clip,
  input  logic                                adv,
  input  logic                                opcode,
  input  logic signed [COORD_BITS-1:0]        sx,
  input  logic signed [COORD_BITS-1:0]        sy,
  input  logic signed [COORD_BITS-1:0]        ex,
  input  logic signed [COORD_BITS-1:0]        ey,
  input  logic [clr_pkg::COLOR_BITS-1:0]      color,
  output logic signed [COORD_BITS-1:0]        px,
  output logic signed [COORD_BITS-1:0]        py,
  output logic [clr_pkg::COLOR_BITS-1:0]      pcolor,
  output logic                                pwe,
  output logic                                pdone,
  output logic                                busy
);
  import clr_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam int E = COORD_BITS + 3;

  // line state
  logic signed [COORD_BITS-1:0] cur_x, cur_y, major_end;
  logic signed [E-1:0]          error_term, diag_inc, straight_inc;
  logic                         minor_neg, steep;
  logic [COLOR_BITS-1:0]        line_color;

  // start setup
  logic signed [D-1:0]          dx, dy, adx, ady, dmaj, dmin;
  logic signed [E-1:0]          dmin_e, dmaj_e, err_s, diag_s, straight_s;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by, end_s;
  logic                         steep_s, swap, mneg_s, busy_s;

  // step
  logic                         move, busy_step;
  logic signed [E-1:0]          err_step;
  logic signed [COORD_BITS-1:0] maj_inc, minor, minor_step, nx, ny;

  // result
  logic                         is_start, in_view;
  logic signed [COORD_BITS-1:0] ox, oy;

  always_comb begin
    dx      = D'(sx) - D'(ex);
    dy      = D'(sy) - D'(ey);
    adx     = dx[D-1] ? -dx : dx;
    ady     = dy[D-1] ? -dy : dy;
    steep_s = adx < ady;
    swap    = steep_s ? (sy > ey) : (sx > ex);
    ax      = swap ? ex : sx;
    ay      = swap ? ey : sy;
    bx      = swap ? sx : ex;
    by      = swap ? sy : ey;
    mneg_s  = steep_s ? !(bx > ax) : !(by > ay);
    dmaj    = steep_s ? (D'(by) - D'(ay)) : (D'(bx) - D'(ax));
    dmin    = steep_s ? adx : ady;
    end_s   = steep_s ? by : bx;
    busy_s  = (steep_s ? ay : ax) != end_s;
    dmin_e     = E'(dmin);
    dmaj_e     = E'(dmaj);
    err_s      = (dmin_e <<< 1) - dmaj_e;
    diag_s     = (dmin_e - dmaj_e) <<< 1;
    straight_s = dmin_e <<< 1;
  end

  always_comb begin
    move       = !error_term[E-1];
    err_step   = error_term + (move ? diag_inc : straight_inc);
    maj_inc    = (steep ? cur_y : cur_x) + COORD_BITS'(1);
    minor      = steep ? cur_x : cur_y;
    if (!move) begin
      minor_step = minor;
    end else if (minor_neg) begin
      minor_step = minor - COORD_BITS'(1);
    end else begin
      minor_step = minor + COORD_BITS'(1);
    end
    nx         = steep ? minor_step : maj_inc;
    ny         = steep ? maj_inc : minor_step;
    busy_step  = maj_inc < major_end;
  end

  always_comb begin
    is_start = opcode == OP_START;
    ox       = is_start ? ax : nx;
    oy       = is_start ? ay : ny;
    in_view  = ($signed(ox) >= $signed({1'b0, clip.left}))  &&
               ($signed(ox) <= $signed({1'b0, clip.right})) &&
               ($signed(oy) >= $signed({1'b0, clip.top}))   &&
               ($signed(oy) <= $signed({1'b0, clip.bottom}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (adv) begin
      if (is_start) begin
        busy <= busy_s;
      end else if (busy) begin
        busy <= busy_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (is_start) begin
        cur_x        <= ax;
        cur_y        <= ay;
        major_end    <= end_s;
        error_term   <= err_s;
        diag_inc     <= diag_s;
        straight_inc <= straight_s;
        minor_neg    <= mneg_s;
        steep        <= steep_s;
        line_color   <= color;
        px           <= ax;
        py           <= ay;
        pcolor       <= color;
        pwe          <= in_view;
        pdone        <= !busy_s;
      end else if (busy) begin
        cur_x        <= nx;
        cur_y        <= ny;
        error_term   <= err_step;
        px           <= nx;
        py           <= ny;
        pcolor       <= line_color;
        pwe          <= in_view;
        pdone        <= !busy_step;
      end else begin
        // idle step: blank pixel, flag done
        px           <= '0;
        py           <= '0;
        pcolor       <= '0;
        pwe          <= 1'b0;
        pdone        <= 1'b1;
      end
    end
  end

endmodule

// ----- src/clipped_line_rasterizer.sv -----
// Channel  Direction  Payload
// items    sink       opcode, start_x, start_y, end_x, end_y, draw_color
// pixels   source     pixel_x, pixel_y, pixel_color, write_enable, line_done
// cfg      write      cfg_we, cfg_index, cfg_data (clip window)
//
// One pixel per cycle while pixels is not stalled.
// The input register feeds the setup/step logic, which loads the result register.
// rst (synchronous) clears the valid flags and the line-busy flag and restores
// the default clip window.
// A stall on pixels holds the result register and the input register; items stays
// ready while the input register is empty or moving forward.
module clipped_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [clr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [clr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  clr_in_if.sink                            items,
  clr_out_if.source                         pixels
);
  import clr_pkg::*;

  clip_t                        clip;
  logic                         ir_valid, adv, ov, line_busy;
  logic                         ir_opcode;
  logic signed [COORD_BITS-1:0] ir_sx, ir_sy, ir_ex, ir_ey;
  logic [COLOR_BITS-1:0]        ir_color;

  assign adv          = ir_valid && (!ov || pixels.ready);
  assign items.ready  = !ir_valid || adv;
  assign pixels.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
      ov       <= 1'b0;
    end else begin
      if (items.ready) begin
        ir_valid <= items.valid;
      end
      if (adv) begin
        ov <= 1'b1;
      end else if (pixels.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // capture on transfer
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      ir_opcode <= items.opcode;
      ir_sx     <= items.start_x;
      ir_sy     <= items.start_y;
      ir_ex     <= items.end_x;
      ir_ey     <= items.end_y;
      ir_color  <= items.draw_color;
    end
  end

  clr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clip      (clip)
  );

  clr_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .clip   (clip),
    .adv    (adv),
    .opcode (ir_opcode),
    .sx     (ir_sx),
    .sy     (ir_sy),
    .ex     (ir_ex),
    .ey     (ir_ey),
    .color  (ir_color),
    .px     (pixels.pixel_x),
    .py     (pixels.pixel_y),
    .pcolor (pixels.pixel_color),
    .pwe    (pixels.write_enable),
    .pdone  (pixels.line_done),
    .busy   (line_busy)
  );

`ifndef SYNTHESIS
  a_ir_hold: assert property (@(posedge clk) disable iff (rst)
    ir_valid && !adv |=> ir_valid && $stable(ir_opcode) && $stable(ir_sx))
    else $error("input register lost an item while stalled");

  a_we_in_window: assert property (@(posedge clk) disable iff (rst)
    ov && pixels.write_enable |->
      ($signed(pixels.pixel_x) >= $signed({1'b0, clip.left})) &&
      ($signed(pixels.pixel_x) <= $signed({1'b0, clip.right})) &&
      ($signed(pixels.pixel_y) >= $signed({1'b0, clip.top})) &&
      ($signed(pixels.pixel_y) <= $signed({1'b0, clip.bottom})))
    else $error("write enable outside clip window");

  a_open_line_busy: assert property (@(posedge clk) disable iff (rst)
    ov && !pixels.line_done |-> line_busy)
    else $error("pixel not marked done but line is idle");

  a_idle_blank: assert property (@(posedge clk) disable iff (rst)
    adv && ir_opcode == OP_STEP && !line_busy |=>
      pixels.line_done && !pixels.write_enable)
    else $error("idle step produced a drawable pixel");
`endif

endmodule
